[design/umarm_pkg.sv]
// Shared types, opcodes and encoding constants for the UM to AArch64 translator.
// No dependencies; every design file imports this package.
package umarm_pkg;

    localparam int CHUNK_WORDS     = 5;
    localparam int IDX_W           = 3;
    localparam int QUEUE_DEPTH_DEF = 2;
    localparam int APB_ADDR_W      = 5;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CHUNK_WORDS - 1);

    // Register indexes on the configuration port
    localparam logic [2:0] REG_BASE_REG      = 3'd0;
    localparam logic [2:0] REG_CALL_CODE_REG = 3'd1;
    localparam logic [2:0] REG_CODE_OUTPUT   = 3'd2;
    localparam logic [2:0] REG_CODE_INPUT    = 3'd3;
    localparam logic [2:0] REG_CODE_UNMAP    = 3'd4;

    typedef enum logic [3:0] {
        OP_CMOV     = 4'd0,
        OP_LOAD     = 4'd1,
        OP_STORE    = 4'd2,
        OP_ADD      = 4'd3,
        OP_MUL      = 4'd4,
        OP_DIV      = 4'd5,
        OP_NAND     = 4'd6,
        OP_HALT     = 4'd7,
        OP_MAP      = 4'd8,
        OP_FREE_SEG = 4'd9,
        OP_OUTPUT   = 4'd10,
        OP_INPUT    = 4'd11,
        OP_LOADPROG = 4'd12,
        OP_LOADVAL  = 4'd13,
        OP_BAD0     = 4'd14,
        OP_BAD1     = 4'd15
    } op_t;

    localparam logic [31:0] NOP_WORD    = 32'hD503201F;
    localparam logic [31:0] MOVZ_BASE   = 32'h52800000;
    localparam logic [31:0] MOVK_BASE   = 32'h72A00000;
    localparam logic [31:0] CMP_BASE    = 32'h7100001F;
    localparam logic [31:0] CSEL_BASE   = 32'h1A800000;
    localparam logic [31:0] LDR_SEG     = 32'hF8605B89;
    localparam logic [31:0] LDR_W_BASE  = 32'hB8605920;
    localparam logic [31:0] STR_W_BASE  = 32'hB8205920;
    localparam logic [31:0] ADD_BASE    = 32'h0B000000;
    localparam logic [31:0] MUL_BASE    = 32'h1B007C00;
    localparam logic [31:0] UDIV_BASE   = 32'h1AC00800;
    localparam logic [31:0] AND_BASE    = 32'h0A000009;
    localparam logic [31:0] MVN_BASE    = 32'h2A2903E0;
    localparam logic [31:0] MOV_X27_0   = 32'hD280001B;
    localparam logic [31:0] RET_WORD    = 32'hD65F03C0;
    localparam logic [31:0] MOV_W_BASE  = 32'h2A0003E0;
    localparam logic [31:0] MOV_W10     = 32'h2A0003EA;
    localparam logic [31:0] PUSH_LR     = 32'hF81F0FFE;
    localparam logic [31:0] POP_LR      = 32'hF84107FE;
    localparam logic [31:0] BLR_X12     = 32'hD63F0180;
    localparam logic [31:0] BLR_X15     = 32'hD63F01E0;
    localparam logic [31:0] BR_X15      = 32'hD61F01E0;
    localparam logic [31:0] ADR_X13     = 32'h1000004D;
    localparam logic [31:0] CBNZ_BASE   = 32'h35000040;

    typedef struct packed {
        logic [4:0]  base_reg;
        logic [4:0]  call_code_reg;
        logic [15:0] code_output;
        logic [15:0] code_input;
        logic [15:0] code_unmap;
    } cfg_t;

    // One classified UM word with its registers already mapped
    typedef struct packed {
        op_t         op;
        logic [4:0]  ra;
        logic [4:0]  rb;
        logic [4:0]  rc;
        logic [24:0] val;
    } dec_t;

    function automatic logic [31:0] movz_code(input logic [15:0] code, input logic [4:0] rd);
        return MOVZ_BASE | {11'd0, code, rd};
    endfunction

    // Word k of the chunk for one decoded instruction
    function automatic logic [31:0] chunk_word(input dec_t d, input logic [IDX_W-1:0] k,
                                               input cfg_t cfg);
        logic [31:0] w0, w1, w2, w3, w4;
        logic [31:0] ra, rb, rc;
        logic [31:0] res;
        ra = {27'd0, d.ra};
        rb = {27'd0, d.rb};
        rc = {27'd0, d.rc};
        w0 = 32'd0;
        w1 = 32'd0;
        w2 = NOP_WORD;
        w3 = NOP_WORD;
        w4 = NOP_WORD;
        case (d.op)
            OP_CMOV:
            begin
                w0 = CMP_BASE | (rc << 5);
                w1 = CSEL_BASE | ra | (rb << 5) | (ra << 16) | 32'h1000;
            end
            OP_LOAD:
            begin
                w0 = LDR_SEG | (rb << 16);
                w1 = LDR_W_BASE | (rc << 16) | ra;
            end
            OP_STORE:
            begin
                w0 = LDR_SEG | (ra << 16);
                w1 = STR_W_BASE | (rb << 16) | rc;
            end
            OP_ADD:
            begin
                w0 = ADD_BASE | ra | (rb << 5) | (rc << 16);
                w1 = NOP_WORD;
            end
            OP_MUL:
            begin
                w0 = MUL_BASE | ra | (rb << 5) | (rc << 16);
                w1 = NOP_WORD;
            end
            OP_DIV:
            begin
                w0 = UDIV_BASE | ra | (rb << 5) | (rc << 16);
                w1 = NOP_WORD;
            end
            OP_NAND:
            begin
                w0 = AND_BASE | (rb << 5) | (rc << 16);
                w1 = MVN_BASE | ra;
            end
            OP_HALT:
            begin
                w0 = MOV_X27_0;
                w1 = RET_WORD;
                w2 = 32'd0;
                w3 = 32'd0;
                w4 = 32'd0;
            end
            OP_MAP:
            begin
                w0 = MOV_W_BASE | (rc << 16);
                w1 = PUSH_LR;
                w2 = BLR_X12;
                w3 = POP_LR;
                w4 = MOV_W_BASE | rb;
            end
            OP_FREE_SEG:
            begin
                w0 = MOV_W_BASE | (rc << 16);
                w1 = movz_code(cfg.code_unmap, cfg.call_code_reg);
                w2 = PUSH_LR;
                w3 = BLR_X15;
                w4 = POP_LR;
            end
            OP_OUTPUT:
            begin
                w0 = MOV_W_BASE | (rc << 16);
                w1 = movz_code(cfg.code_output, cfg.call_code_reg);
                w2 = ADR_X13;
                w3 = BR_X15;
            end
            OP_INPUT:
            begin
                w0 = movz_code(cfg.code_input, cfg.call_code_reg);
                w1 = ADR_X13;
                w2 = BR_X15;
                w3 = MOV_W_BASE | rc;
            end
            OP_LOADPROG:
            begin
                w0 = MOV_W10 | (rc << 16);
                w1 = CBNZ_BASE | rb;
                w2 = RET_WORD;
                w3 = MOV_W_BASE | (rb << 16);
                w4 = BR_X15;
            end
            OP_LOADVAL:
            begin
                w0 = MOVZ_BASE | {11'd0, d.val[15:0], d.ra};
                w1 = MOVK_BASE | {18'd0, d.val[24:16], d.ra};
            end
            default:
            begin
                w2 = 32'd0;
                w3 = 32'd0;
                w4 = 32'd0;
            end
        endcase
        case (k)
            3'd0:    res = w0;
            3'd1:    res = w1;
            3'd2:    res = w2;
            3'd3:    res = w3;
            3'd4:    res = w4;
            default: res = 32'd0;
        endcase
        return res;
    endfunction

endpackage

[design/umarm_front.sv]
// Front end: accepts UM words, classifies the opcode and maps registers.
// Depends on umarm_pkg; feeds umarm_queue.
module umarm_front
    import umarm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] in_word,
    input  logic [4:0]  base_reg,
    output logic        push,
    output dec_t        push_data,
    input  logic        queue_ready
);

    logic valid_reg;
    logic valid_next;
    dec_t dec_reg;
    dec_t dec_next;
    op_t  op_in;

    assign op_in     = op_t'(in_word[31:28]);
    assign in_ready  = !valid_reg || queue_ready;
    assign push      = valid_reg && queue_ready;
    assign push_data = dec_reg;

    always_comb
    begin
        dec_next.op  = op_in;
        // Load-immediate keeps its target register in the top bits
        if (op_in == OP_LOADVAL)
            dec_next.ra = base_reg + {2'd0, in_word[27:25]};
        else
            dec_next.ra = base_reg + {2'd0, in_word[8:6]};
        dec_next.rb  = base_reg + {2'd0, in_word[5:3]};
        dec_next.rc  = base_reg + {2'd0, in_word[2:0]};
        dec_next.val = in_word[24:0];
        if (in_valid && in_ready)
            valid_next = 1'b1;
        else if (push)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            dec_reg <= dec_next;
    end

endmodule

[design/umarm_queue.sv]
// Short queue of decoded instructions between front and back end.
// Depends on umarm_pkg for the entry type.
module umarm_queue
    import umarm_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  dec_t push_data,
    output logic push_ready,
    input  logic pop,
    output logic pop_valid,
    output dec_t pop_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    dec_t             mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign push_ready = count_reg != CNT_W'(DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_data   = mem[rd_ptr_reg];
    assign do_push    = push && push_ready;
    assign do_pop     = pop && pop_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= push_data;
    end

endmodule

[design/umarm_back.sv]
// Back end: expands the queue head into its five-word chunk, one word a cycle unless the output is stalled.
// Depends on umarm_pkg for the encoder function and types.
module umarm_back
    import umarm_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             head_valid,
    input  dec_t             head,
    output logic             pop,
    input  cfg_t             cfg,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [31:0]      out_word,
    output logic [IDX_W-1:0] out_index,
    output logic             out_last
);

    logic             valid_reg;
    logic             valid_next;
    logic [31:0]      word_reg;
    logic [IDX_W-1:0] index_reg;
    logic             last_reg;
    logic [IDX_W-1:0] cnt_reg;
    logic [IDX_W-1:0] cnt_next;
    logic             load;
    logic             emit;

    // Output register is free when empty or being drained this cycle
    assign load = !valid_reg || out_ready;
    assign emit = load && head_valid;
    assign pop  = emit && (cnt_reg == LAST_IDX);

    assign out_valid = valid_reg;
    assign out_word  = word_reg;
    assign out_index = index_reg;
    assign out_last  = last_reg;

    always_comb
    begin
        cnt_next   = cnt_reg;
        valid_next = valid_reg;
        if (load)
            valid_next = head_valid;
        if (emit)
            cnt_next = (cnt_reg == LAST_IDX) ? '0 : cnt_reg + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            word_reg  <= chunk_word(head, cnt_reg, cfg);
            index_reg <= cnt_reg;
            last_reg  <= (cnt_reg == LAST_IDX);
        end
    end

endmodule

[design/um_to_arm64_instruction_translator_top.sv]
// Top level of the UM to AArch64 translator: APB registers, front, queue, back.
// Depends on umarm_pkg, umarm_front, umarm_queue and umarm_back.
//
// Each UM word accepted on s_axis yields five AArch64 words on m_axis, the fifth
// with tlast set. The output channel moves one word a cycle while m_axis_tready is
// high, so under steady flow the five-word emission in the back end sets the rate
// at which UM words are taken. An accepted word passes the front register, then
// a queue entry, then the output register before it appears at m_axis. The queue
// of QUEUE_DEPTH decoded words lets input keep flowing while output is stalled.
// The user writes registers over APB only while no chunk is in flight; not enforced.
module um_to_arm64_instruction_translator_top
    import umarm_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [31:0]           s_axis_tdata,   // [31:0] um_word
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [39:0]           m_axis_tdata,   // [31:0] arm_word, [34:32] word_index
    output logic                  m_axis_tlast,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    cfg_t             cfg_reg;
    logic             cfg_wr;
    logic [2:0]       reg_sel;
    logic             push;
    dec_t             push_data;
    logic             queue_ready;
    logic             pop;
    logic             head_valid;
    dec_t             head;
    logic [31:0]      out_word;
    logic [IDX_W-1:0] out_index;

    assign pready  = 1'b1;
    assign reg_sel = paddr[4:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.base_reg      <= 5'd19;
            cfg_reg.call_code_reg <= 5'd1;
            cfg_reg.code_output   <= 16'd0;
            cfg_reg.code_input    <= 16'd1;
            cfg_reg.code_unmap    <= 16'd2;
        end
        else if (cfg_wr)
        begin
            case (reg_sel)
                REG_BASE_REG:      cfg_reg.base_reg      <= pwdata[4:0];
                REG_CALL_CODE_REG: cfg_reg.call_code_reg <= pwdata[4:0];
                REG_CODE_OUTPUT:   cfg_reg.code_output   <= pwdata[15:0];
                REG_CODE_INPUT:    cfg_reg.code_input    <= pwdata[15:0];
                REG_CODE_UNMAP:    cfg_reg.code_unmap    <= pwdata[15:0];
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_sel)
            REG_BASE_REG:      prdata = {27'd0, cfg_reg.base_reg};
            REG_CALL_CODE_REG: prdata = {27'd0, cfg_reg.call_code_reg};
            REG_CODE_OUTPUT:   prdata = {16'd0, cfg_reg.code_output};
            REG_CODE_INPUT:    prdata = {16'd0, cfg_reg.code_input};
            REG_CODE_UNMAP:    prdata = {16'd0, cfg_reg.code_unmap};
            default:           prdata = 32'd0;
        endcase
    end

    umarm_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .in_word     (s_axis_tdata),
        .base_reg    (cfg_reg.base_reg),
        .push        (push),
        .push_data   (push_data),
        .queue_ready (queue_ready)
    );

    umarm_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  (push_data),
        .push_ready (queue_ready),
        .pop        (pop),
        .pop_valid  (head_valid),
        .pop_data   (head)
    );

    umarm_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .cfg        (cfg_reg),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_word   (out_word),
        .out_index  (out_index),
        .out_last   (m_axis_tlast)
    );

    assign m_axis_tdata = {5'd0, out_index, out_word};

endmodule

[design/umarm_checker.sv]
// Port-level checks for the translator top level, bound in below.
// Depends on umarm_pkg; watches only the top-level ports.
module umarm_checker
    import umarm_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  s_axis_tvalid,
    input logic                  s_axis_tready,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [39:0]           m_axis_tdata,
    input logic                  m_axis_tlast
);

    logic             in_acc;
    logic             out_acc;
    logic [IDX_W-1:0] exp_idx_reg;
    logic [5:0]       pending_reg;

    assign in_acc  = s_axis_tvalid && s_axis_tready;
    assign out_acc = m_axis_tvalid && m_axis_tready;

    // Track expected word position and number of chunks not yet finished
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exp_idx_reg <= '0;
            pending_reg <= '0;
        end
        else
        begin
            if (out_acc)
                exp_idx_reg <= m_axis_tlast ? '0 : exp_idx_reg + 1'b1;
            pending_reg <= pending_reg + {5'd0, in_acc} - {5'd0, out_acc && m_axis_tlast};
        end
    end

    a_last_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tlast == (m_axis_tdata[34:32] == LAST_IDX)))
        else $error("tlast does not match final word position");

    a_index_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_acc |-> (m_axis_tdata[34:32] == exp_idx_reg))
        else $error("word position out of order");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (pending_reg != '0))
        else $error("output word without an accepted input");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled output word changed");

endmodule

bind um_to_arm64_instruction_translator_top umarm_checker u_checker (.*);
